### design/ksm_pkg.sv
// shared types and constants for the kernel splat source map
// no dependencies
package ksm_pkg;

  localparam int unsigned CELL_W     = 14;
  localparam int unsigned KIDX_W     = 12;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned SIZE_W     = 8;
  localparam int unsigned RAD_W      = 3;
  localparam int unsigned CNT_W      = 8;

  // operation codes of a request
  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_APPLY   = 3'd2;
  localparam logic [OP_W-1:0] OP_KWRITE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd3;

  typedef enum logic [2:0] {
    K_ADD    = 3'd0,
    K_REMOVE = 3'd1,
    K_APPLY  = 3'd2,
    K_KWRITE = 3'd3,
    K_READ   = 3'd4,
    K_NOP    = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CELL_W-1:0] cidx;
    logic [KIDX_W-1:0] kidx;
    logic [VAL_W-1:0]  kval;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic [RAD_W-1:0]  radius;
  } cfg_t;

endpackage

### design/ksm_front.sv
// front end: takes requests off the input stream and classifies them
// depends on ksm_pkg
module ksm_front import ksm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [63:0]            s_axis_tdata_i,
  input  logic [OP_W-1:0]        s_axis_tuser_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  logic                   cmd_full_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  kind_e kind;

  always_comb begin
    unique case (s_axis_tuser_i)
      OP_ADD:    kind = K_ADD;
      OP_REMOVE: kind = K_REMOVE;
      OP_APPLY:  kind = K_APPLY;
      OP_KWRITE: kind = K_KWRITE;
      OP_READ:   kind = K_READ;
      default:   kind = K_NOP;
    endcase
  end

  assign s_axis_tready_o = !valid_q || !cmd_full_i;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (valid_q && !cmd_full_i) valid_d = 1'b0;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      valid_d    = 1'b1;
      cmd_d.kind = kind;
      cmd_d.cidx = s_axis_tdata_i[13:0];
      cmd_d.kidx = s_axis_tdata_i[25:14];
      cmd_d.kval = s_axis_tdata_i[57:26];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

### design/ksm_fifo.sv
// two entry request queue between front and back
// depends on ksm_pkg
module ksm_fifo import ksm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = !wptr_q;
    if (pop_i) rptr_d = !rptr_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rptr_q];

endmodule

### design/ksm_back.sv
// back end: owns the map, counter and kernel memories and runs each request
// depends on ksm_pkg
module ksm_back import ksm_pkg::*; #(
  parameter int unsigned MAP_CELLS      = 16384,
  parameter int unsigned KERNEL_ENTRIES = 4096,
  parameter int unsigned MAX_RADIUS     = 7,
  parameter int unsigned MAX_SIDE       = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VAL_W-1:0] out_value_o,
  output logic             out_status_o
);

  localparam int unsigned MAW = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int unsigned KAW = (KERNEL_ENTRIES > 1) ? $clog2(KERNEL_ENTRIES) : 1;
  localparam int unsigned TW  = ((MAW > 19) ? MAW : 19) + 3;

  typedef enum logic [14:0] {
    ST_CLR   = 15'b000000000000001,
    ST_IDLE  = 15'b000000000000010,
    ST_EXEC  = 15'b000000000000100,
    ST_CNT   = 15'b000000000001000,
    ST_MAPRD = 15'b000000000010000,
    ST_SCAN  = 15'b000000000100000,
    ST_CHK   = 15'b000000001000000,
    ST_ZST   = 15'b000000010000000,
    ST_YST   = 15'b000000100000000,
    ST_XST   = 15'b000001000000000,
    ST_STEP  = 15'b000010000000000,
    ST_ACC   = 15'b000100000000000,
    ST_ADV   = 15'b001000000000000,
    ST_NEXT  = 15'b010000000000000,
    ST_RESP  = 15'b100000000000000
  } state_e;

  cmd_t             cmd_q, cmd_d;

  // memories
  logic [VAL_W-1:0] fmap_mem [MAP_CELLS];
  logic [CNT_W-1:0] pend_mem [MAP_CELLS];
  logic [VAL_W-1:0] kern_mem [KERNEL_ENTRIES];

  logic             fmap_we, pend_we, kern_we;
  logic [MAW-1:0]   fmap_waddr, fmap_raddr, pend_waddr, pend_raddr;
  logic [KAW-1:0]   kern_waddr, kern_raddr;
  logic [VAL_W-1:0] fmap_wdata, fmap_rdata_q, kern_rdata_q;
  logic [CNT_W-1:0] pend_wdata, pend_rdata_q;

  always_ff @(posedge clk_i) begin
    if (fmap_we) fmap_mem[fmap_waddr] <= fmap_wdata;
    fmap_rdata_q <= fmap_mem[fmap_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    pend_rdata_q <= pend_mem[pend_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (kern_we) kern_mem[kern_waddr] <= cmd_q.kval;
    kern_rdata_q <= kern_mem[kern_raddr];
  end

  // effective geometry
  logic [SIZE_W-1:0] sx, sy, sz;
  logic [RAD_W-1:0]  r;
  logic [3:0]        side;
  logic              three_d;
  logic [15:0]       sxy_q;
  logic [23:0]       lat_q;
  logic [7:0]        sq_q;
  logic [11:0]       kcount_q;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] e;
    e = v;
    if (v == '0) e = SIZE_W'(1);
    else if (32'(v) > MAX_SIDE) e = SIZE_W'(MAX_SIDE);
    return e;
  endfunction

  assign sx      = eff_size(cfg_i.size_x);
  assign sy      = eff_size(cfg_i.size_y);
  assign sz      = eff_size(cfg_i.size_z);
  assign r       = (32'(cfg_i.radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : cfg_i.radius;
  assign side    = {r, 1'b1};
  assign three_d = sz > SIZE_W'(1);

  always_ff @(posedge clk_i) begin
    sxy_q    <= 16'(sx) * 16'(sy);
    lat_q    <= 24'(sxy_q) * 24'(sz);
    sq_q     <= 8'(side) * 8'(side);
    kcount_q <= three_d ? 12'(sq_q) * 12'(side) : 12'(sq_q);
  end

  // control and walk registers
  state_e                  state_q, state_d;
  logic [MAW-1:0]          clr_q, clr_d, i_q, i_d;
  logic [SIZE_W-1:0]       cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic signed [4:0]       dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic signed [TW-1:0]    zb_q, zb_d, yb_q, yb_d, t_q, t_d;
  logic [11:0]             k_q, k_d;
  logic                    neg_q, neg_d;
  logic [VAL_W-1:0]        res_val_q, res_val_d, out_val_q, out_val_d;
  logic                    res_st_q, res_st_d, out_st_q, out_st_d;
  logic                    out_valid_q, out_valid_d;

  logic                    cell_ok, in_lat;
  logic signed [4:0]       rs, zhi;
  logic signed [9:0]       tx, ty, tz;
  logic                    tgt_ok;
  logic [18:0]             rsxy;
  logic [10:0]             rsx;
  logic signed [VAL_W:0]   sum;
  logic signed [CNT_W-1:0] cnt;

  assign rs      = $signed({2'b00, r});
  assign zhi     = three_d ? rs : 5'sd0;
  assign cell_ok = (24'(cmd_q.cidx) < lat_q) && (32'(cmd_q.cidx) < MAP_CELLS);
  assign in_lat  = 24'(i_q) < lat_q;
  assign tx      = $signed({2'b00, cx_q}) + 10'(dx_q);
  assign ty      = $signed({2'b00, cy_q}) + 10'(dy_q);
  assign tz      = $signed({2'b00, cz_q}) + 10'(dz_q);
  assign tgt_ok  = (tx >= 0) && (tx < $signed({2'b00, sx})) &&
                   (ty >= 0) && (ty < $signed({2'b00, sy})) &&
                   (tz >= 0) && (tz < $signed({2'b00, sz})) &&
                   !t_q[TW-1] && (t_q < $signed(TW'(MAP_CELLS))) &&
                   (32'(k_q) < KERNEL_ENTRIES);
  assign rsxy    = 19'(r) * 19'(sxy_q);
  assign rsx     = 11'(r) * 11'(sx);
  assign cnt     = $signed(pend_rdata_q);
  assign sum     = neg_q ?
                   $signed({fmap_rdata_q[VAL_W-1], fmap_rdata_q}) -
                   $signed({kern_rdata_q[VAL_W-1], kern_rdata_q}) :
                   $signed({fmap_rdata_q[VAL_W-1], fmap_rdata_q}) +
                   $signed({kern_rdata_q[VAL_W-1], kern_rdata_q});

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    i_d         = i_q;
    cmd_d       = cmd_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    dz_d        = dz_q;
    zb_d        = zb_q;
    yb_d        = yb_q;
    t_d         = t_q;
    k_d         = k_q;
    neg_d       = neg_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q;
    fmap_we     = 1'b0;
    pend_we     = 1'b0;
    kern_we     = 1'b0;
    fmap_waddr  = MAW'(cmd_q.cidx);
    fmap_wdata  = '0;
    fmap_raddr  = MAW'(cmd_q.cidx);
    pend_waddr  = MAW'(cmd_q.cidx);
    pend_wdata  = '0;
    pend_raddr  = MAW'(cmd_q.cidx);
    kern_waddr  = KAW'(cmd_q.kidx);
    kern_raddr  = KAW'(k_q);

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_CLR: begin
        fmap_we    = 1'b1;
        pend_we    = 1'b1;
        fmap_waddr = clr_q;
        pend_waddr = clr_q;
        clr_d      = clr_q + MAW'(1);
        if (clr_q == MAW'(MAP_CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_val_d = '0;
        res_st_d  = 1'b0;
        state_d   = ST_RESP;
        case (cmd_q.kind)
          K_ADD, K_REMOVE: begin
            if (cell_ok) state_d = ST_CNT;
            else res_st_d = 1'b1;
          end
          K_READ: begin
            if (cell_ok) state_d = ST_MAPRD;
            else res_st_d = 1'b1;
          end
          K_KWRITE: begin
            if ((cmd_q.kidx >= kcount_q) || (32'(cmd_q.kidx) >= KERNEL_ENTRIES))
              res_st_d = 1'b1;
            else kern_we = 1'b1;
          end
          K_APPLY: begin
            i_d     = '0;
            cx_d    = '0;
            cy_d    = '0;
            cz_d    = '0;
            state_d = ST_SCAN;
          end
          default: ;
        endcase
      end
      ST_CNT: begin
        pend_we    = 1'b1;
        pend_wdata = pend_rdata_q;
        if (cmd_q.kind == K_ADD && cnt < 8'sd127) pend_wdata = pend_rdata_q + 8'd1;
        if (cmd_q.kind == K_REMOVE && cnt > -8'sd127) pend_wdata = pend_rdata_q - 8'd1;
        state_d = ST_RESP;
      end
      ST_MAPRD: begin
        res_val_d = fmap_rdata_q;
        state_d   = ST_RESP;
      end
      ST_SCAN: begin
        pend_raddr = i_q;
        state_d    = ST_CHK;
      end
      ST_CHK: begin
        // every counter is cleared, cells outside the lattice too
        pend_we    = 1'b1;
        pend_waddr = i_q;
        neg_d      = cnt < 0;
        state_d    = (cnt != 0 && in_lat) ? ST_ZST : ST_NEXT;
      end
      ST_ZST: begin
        dz_d    = three_d ? -rs : 5'sd0;
        zb_d    = $signed(TW'(i_q)) - (three_d ? $signed(TW'(rsxy)) : $signed(TW'(0)));
        k_d     = '0;
        state_d = ST_YST;
      end
      ST_YST: begin
        dy_d    = -rs;
        yb_d    = zb_q - $signed(TW'(rsx));
        state_d = ST_XST;
      end
      ST_XST: begin
        dx_d    = -rs;
        t_d     = yb_q - $signed(TW'(r));
        state_d = ST_STEP;
      end
      ST_STEP: begin
        fmap_raddr = t_q[MAW-1:0];
        state_d    = tgt_ok ? ST_ACC : ST_ADV;
      end
      ST_ACC: begin
        // saturating accumulate into the target cell
        fmap_we    = 1'b1;
        fmap_waddr = t_q[MAW-1:0];
        if (sum[VAL_W] != sum[VAL_W-1])
          fmap_wdata = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        else fmap_wdata = sum[VAL_W-1:0];
        state_d = ST_ADV;
      end
      ST_ADV: begin
        k_d = k_q + 12'd1;
        if (dx_q < rs) begin
          dx_d    = dx_q + 5'sd1;
          t_d     = t_q + $signed(TW'(1));
          state_d = ST_STEP;
        end else if (dy_q < rs) begin
          dy_d    = dy_q + 5'sd1;
          yb_d    = yb_q + $signed(TW'(sx));
          state_d = ST_XST;
        end else if (dz_q < zhi) begin
          dz_d    = dz_q + 5'sd1;
          zb_d    = zb_q + $signed(TW'(sxy_q));
          state_d = ST_YST;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (i_q == MAW'(MAP_CELLS - 1)) begin
          state_d = ST_RESP;
        end else begin
          i_d     = i_q + MAW'(1);
          state_d = ST_SCAN;
          if (cx_q == sx - SIZE_W'(1)) begin
            cx_d = '0;
            if (cy_q == sy - SIZE_W'(1)) begin
              cy_d = '0;
              cz_d = cz_q + SIZE_W'(1);
            end else cy_d = cy_q + SIZE_W'(1);
          end else cx_d = cx_q + SIZE_W'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    cmd_q     <= cmd_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    cz_q      <= cz_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    dz_q      <= dz_d;
    zb_q      <= zb_d;
    yb_q      <= yb_d;
    t_q       <= t_d;
    k_q       <= k_d;
    neg_q     <= neg_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_val_q;
  assign out_status_o = out_st_q;

endmodule

### design/kernel_splat_source_map.sv
// kernel splat source map: a kernel write, an error or an unknown code passes the back end
// states EXEC and RESP, an add or remove EXEC, CNT, RESP, a read EXEC, MAPRD, RESP; a new
// request is taken only in IDLE. apply walks all MAP_CELLS counters (SCAN, CHK, NEXT) and,
// for a lattice cell with a nonzero counter, each kernel entry (STEP, ADV, ACC if in range).
// after reset a clearing pass over the MAP_CELLS cells zeroes map and counters; the front
// still takes up to three requests meanwhile, configuration writes are taken at any time
module kernel_splat_source_map import ksm_pkg::*; #(
  parameter int unsigned MAP_CELLS      = 16384,
  parameter int unsigned KERNEL_ENTRIES = 4096,
  parameter int unsigned MAX_RADIUS     = 7,
  parameter int unsigned MAX_SIDE       = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [63:0]           s_axis_tdata_i,  // cell_index, kernel_index, kernel_value
  input  logic [OP_W-1:0]       s_axis_tuser_i,  // operation
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [VAL_W-1:0]      m_axis_tdata_o,  // map_value
  output logic                  m_axis_tuser_o   // status
);

  // configuration registers
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X: cfg_d.size_x = cfg_data_i;
        CFG_SIZE_Y: cfg_d.size_y = cfg_data_i;
        CFG_SIZE_Z: cfg_d.size_z = cfg_data_i;
        CFG_RADIUS: cfg_d.radius = cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x <= SIZE_W'(100);
      cfg_q.size_y <= SIZE_W'(100);
      cfg_q.size_z <= SIZE_W'(1);
      cfg_q.radius <= RAD_W'(3);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front classifies, queue decouples, back executes
  logic front_valid, fifo_full, fifo_valid, fifo_pop, fifo_push;
  cmd_t front_cmd, fifo_cmd;

  assign fifo_push = front_valid && !fifo_full;

  ksm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (front_valid),
    .cmd_o           (front_cmd),
    .cmd_full_i      (fifo_full)
  );

  ksm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_cmd)
  );

  ksm_back #(
    .MAP_CELLS      (MAP_CELLS),
    .KERNEL_ENTRIES (KERNEL_ENTRIES),
    .MAX_RADIUS     (MAX_RADIUS),
    .MAX_SIDE       (MAX_SIDE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (fifo_valid),
    .cmd_i        (fifo_cmd),
    .cmd_pop_o    (fifo_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

  // queue never pushed when full, never popped when empty
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full) else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> fifo_valid) else $error("request queue underflow");

  // an error answer never carries a map value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("error result with nonzero value");

endmodule
